@@ rtl/phug_pkg.sv @@
// Shared types, constants and the FNV-1a step for the path hash UUID generator.
`default_nettype none
package phug_pkg;

	localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
	localparam logic [63:0] GOLDEN_CONST     = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SEED_FIRST       = FNV_OFFSET_BASIS;
	localparam logic [63:0] SEED_SECOND      = FNV_OFFSET_BASIS ^ GOLDEN_CONST;

	localparam logic [3:0] UUID_VERSION = 4'b0101;
	localparam logic [1:0] UUID_VARIANT = 2'b10;

	localparam int QUEUE_DEPTH = 4;

	// One classified item as it sits in the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} item_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// XOR the byte in, then multiply by the FNV prime 2^40 + 2^8 + 0xb3 as shift-adds.
	function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage
`default_nettype wire

@@ rtl/phug_front.sv @@
// Input stage: accepts items, drops those that carry neither a byte nor an end mark.
`default_nettype none
module phug_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // path_byte
	input  wire logic                s_tuser,   // byte_present
	input  wire logic                s_tlast,   // last_byte
	input  wire phug_pkg::qstat_t    q_stat,
	output logic                     q_push,
	output phug_pkg::item_t          q_wr_item
);

	logic            valid_s1;
	phug_pkg::item_t item_s1;
	logic            take;

	assign q_push    = valid_s1 && !q_stat.full;
	assign s_tready  = !valid_s1 || !q_stat.full;
	assign take      = s_tvalid && s_tready;
	assign q_wr_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			// An item with no byte and no end mark changes nothing, so it is not kept.
			valid_s1 <= s_tuser || s_tlast;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data    <= s_tdata;
			item_s1.present <= s_tuser;
			item_s1.last    <= s_tlast;
		end
	end

endmodule
`default_nettype wire

@@ rtl/phug_queue.sv @@
// Short item queue between the front and the back.
`default_nettype none
module phug_queue #(
	parameter int DEPTH = phug_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire phug_pkg::item_t  wr_item,
	input  wire logic             pop,
	output phug_pkg::item_t       rd_item,
	output phug_pkg::qstat_t      stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	phug_pkg::item_t entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign stat.full  = (count_q == DEPTH_CNT);
	assign stat.empty = (count_q == '0);
	assign rd_item    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/phug_back.sv @@
// Hash engine: runs both FNV-1a hashes and holds the finished UUID for the output.
`default_nettype none
module phug_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire phug_pkg::qstat_t q_stat,
	input  wire phug_pkg::item_t  q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [127:0]          m_tdata    // [63:0] uuid_high, [127:64] uuid_low
);

	logic [63:0] hash_a_q;
	logic [63:0] hash_b_q;
	logic [63:0] next_a;
	logic [63:0] next_b;
	logic        out_valid_q;
	logic [63:0] uuid_high_q;
	logic [63:0] uuid_low_q;
	logic        out_free;

	// The output register may be refilled in the cycle its item is taken.
	assign out_free = !out_valid_q || m_tready;
	assign q_pop    = !q_stat.empty && (!q_item.last || out_free);

	always_comb begin
		next_a = hash_a_q;
		next_b = hash_b_q;
		if (q_item.present) begin
			next_a = phug_pkg::fnv_absorb(hash_a_q, q_item.data);
			next_b = phug_pkg::fnv_absorb(hash_b_q, q_item.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_a_q    <= phug_pkg::SEED_FIRST;
			hash_b_q    <= phug_pkg::SEED_SECOND;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_item.last) begin
				hash_a_q    <= phug_pkg::SEED_FIRST;
				hash_b_q    <= phug_pkg::SEED_SECOND;
				out_valid_q <= 1'b1;
			end else begin
				if (q_pop) begin
					hash_a_q <= next_a;
					hash_b_q <= next_b;
				end
				if (m_tready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			uuid_high_q <= {next_a[63:16], phug_pkg::UUID_VERSION, next_a[11:0]};
			uuid_low_q  <= {phug_pkg::UUID_VARIANT, next_b[61:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {uuid_low_q, uuid_high_q};

endmodule
`default_nettype wire

@@ rtl/path_hash_uuid_generator.sv @@
// Path hash UUID generator: two FNV-1a 64 hashes over a byte stream, one UUID per string.
// Throughput: one item per cycle, but a full queue or a waiting finished UUID can hold input;
// each byte is absorbed by a single shift-add multiply stage. An item that ends a string
// passes the input register, then a queue entry, then the UUID output register.
// Reset (arst_n low, asynchronous) empties the queue, drops any pending UUID and
// returns both hashes to their seeds.
`default_nettype none
module path_hash_uuid_generator #(
	parameter int QUEUE_DEPTH = phug_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] path_byte
	input  wire logic         s_tuser,   // [0] byte_present
	input  wire logic         s_tlast,   // last_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata    // [63:0] uuid_high, [127:64] uuid_low
);

	phug_pkg::qstat_t q_stat;
	phug_pkg::item_t  q_wr_item;
	phug_pkg::item_t  q_item;
	logic             q_push;
	logic             q_pop;

	phug_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_wr_item (q_wr_item)
	);

	phug_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.rd_item (q_item),
		.stat    (q_stat)
	);

	phug_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// The back never reads from an empty queue.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// A finished UUID that is still waiting is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_item.last && m_tvalid && !m_tready))
		else $error("pending UUID overwritten");

	// Items that neither carry a byte nor end a string never enter the queue.
	a_no_empty_items: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wr_item.present || q_wr_item.last))
		else $error("no-op item queued");

	// A UUID only appears after the back consumed an end-of-string item.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(q_pop && q_item.last))
		else $error("UUID offered without an end-of-string item");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the path hash UUID generator.
module testbench;

	localparam int RANDOM_ITEMS = 650;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE       = 8;
	localparam int N_DIRECTED   = 18;
	localparam int MAX_REPORTS  = 10;

	localparam logic [63:0] FNV_PRIME_64 = 64'd1099511628211;

	// UUID of the empty string: both seeds with version and variant forced.
	localparam logic [63:0] EMPTY_UUID_HIGH = 64'hcbf2_9ce4_8422_5325;
	localparam logic [63:0] EMPTY_UUID_LOW  = 64'h95c5_e55d_fb68_5f30;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
	} uuid_pair_t;

	typedef struct packed {
		logic [7:0]  path_byte;
		logic        present;
		logic        last;
		logic        known;
		uuid_pair_t  uuid;
	} path_row_t;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_pattern_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;   // [7:0] path_byte
	logic         s_tuser = 1'b0;   // [0] byte_present
	logic         s_tlast = 1'b0;   // last_byte
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;          // [63:0] uuid_high, [127:64] uuid_low

	path_hash_uuid_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [63:0] path_hash_a = phug_pkg::SEED_FIRST;
	logic [63:0] path_hash_b = phug_pkg::SEED_SECOND;
	uuid_pair_t  pending_uuids[$];
	uuid_pair_t  oldest_uuid;
	int          mismatches = 0;
	int          items_counted = 0;
	int          burst_left = 0;
	bit          steady = 1'b0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          mode_left = 0;
	rx_pattern_t rx_mode = RX_OPEN;
	int          idle_cycles = 0;

	path_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, '{EMPTY_UUID_HIGH, EMPTY_UUID_LOW}},
		'{8'hff, 1'b0, 1'b1, 1'b1, '{EMPTY_UUID_HIGH, EMPTY_UUID_LOW}},
		'{8'h00, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'hff, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h3c, 1'b0, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'ha5, 1'b1, 1'b1, 1'b0, '{64'd0, 64'd0}},
		'{8'h5a, 1'b1, 1'b1, 1'b0, '{64'd0, 64'd0}},
		'{8'h00, 1'b1, 1'b1, 1'b0, '{64'd0, 64'd0}},
		'{8'hff, 1'b1, 1'b1, 1'b0, '{64'd0, 64'd0}},
		'{8'h2f, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h75, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'hff, 1'b0, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h73, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h72, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h00, 1'b0, 1'b1, 1'b0, '{64'd0, 64'd0}},
		'{8'h00, 1'b0, 1'b1, 1'b1, '{EMPTY_UUID_HIGH, EMPTY_UUID_LOW}},
		'{8'h80, 1'b1, 1'b0, 1'b0, '{64'd0, 64'd0}},
		'{8'h01, 1'b1, 1'b1, 1'b0, '{64'd0, 64'd0}}
	};

	function automatic logic [63:0] fnv1a_mix(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * FNV_PRIME_64;
	endfunction

	// Advances both hashes by one item; returns 1 with the UUID when the string ends.
	function automatic bit hash_path_item(input logic [7:0] b, input logic present,
			input logic last, output uuid_pair_t uuid);
		uuid = '0;
		if (present) begin
			path_hash_a = fnv1a_mix(path_hash_a, b);
			path_hash_b = fnv1a_mix(path_hash_b, b);
		end
		if (!last)
			return 1'b0;
		uuid.high = {path_hash_a[63:16], phug_pkg::UUID_VERSION, path_hash_a[11:0]};
		uuid.low  = {phug_pkg::UUID_VARIANT, path_hash_b[61:0]};
		path_hash_a = phug_pkg::SEED_FIRST;
		path_hash_b = phug_pkg::SEED_SECOND;
		return 1'b1;
	endfunction

	task automatic count_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic send_item(input logic [7:0] b, input logic present, input logic last,
			input logic known, input uuid_pair_t typed_uuid);
		int gap;
		uuid_pair_t uuid;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= present;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (hash_path_item(b, present, last, uuid))
			pending_uuids.push_back(known ? typed_uuid : uuid);
		if (present || last)
			items_counted++;
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (pending_uuids.size() != 0)
			@(posedge clk);
	endtask

	// One path string, mostly printable bytes, with stray empty items mixed in.
	task automatic send_path();
		int len;
		bit join_end;
		logic [7:0] b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
		join_end = 1'($urandom_range(0, 1));
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
			b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h20, 8'h7e))
				: 8'($urandom_range(0, 255));
			send_item(b, 1'b1, join_end && k == len - 1, 1'b0, '0);
		end
		if (len == 0 || !join_end)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
	endtask

	// Receiver: rotating stall patterns, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_requests != hold_served) begin
			hold_served++;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_pattern_t'($urandom_range(RX_OPEN, RX_SPARSE));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
				default:   m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_uuids.size() == 0) begin
				count_mismatch($sformatf("unexpected UUID %h", m_tdata));
			end else begin
				oldest_uuid = pending_uuids.pop_front();
				if (m_tdata[63:0] !== oldest_uuid.high || m_tdata[127:64] !== oldest_uuid.low)
					count_mismatch($sformatf(
						"UUID mismatch: high exp %h got %h, low exp %h got %h",
						oldest_uuid.high, m_tdata[63:0], oldest_uuid.low, m_tdata[127:64]));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("path_hash_uuid_generator verification failed");
			$finish;
		end
	end

	initial begin
		int r;
		bit hold_done;
		bit pause_done;
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(directed_rows[i].path_byte, directed_rows[i].present,
				directed_rows[i].last, directed_rows[i].known, directed_rows[i].uuid);

		items_counted = 0;
		while (items_counted < RANDOM_ITEMS) begin
			if (!hold_done && items_counted >= 150) begin
				// Keep offering items while the receiver is held off so the queue fills.
				hold_done = 1'b1;
				steady = 1'b1;
				hold_requests++;
				repeat (6) send_path();
				steady = 1'b0;
			end
			if (!pause_done && items_counted >= 400) begin
				pause_done = 1'b1;
				wait_for_drain();
			end
			r = $urandom_range(0, 99);
			if (r < 88)
				send_path();
			else if (r < 94)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
			else
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
		end

		wait_for_drain();
		repeat (SETTLE) @(posedge clk);
		if (pending_uuids.size() != 0)
			count_mismatch($sformatf("%0d UUIDs never arrived", pending_uuids.size()));
		if (mismatches == 0)
			$display("path_hash_uuid_generator verification clean");
		else
			$display("path_hash_uuid_generator verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/phug_pkg.sv
rtl/phug_front.sv
rtl/phug_queue.sv
rtl/phug_back.sv
rtl/path_hash_uuid_generator.sv
dv/testbench.sv
